// ===== design/assert_macros.svh =====
// assertion macros used by neural_activation_unit_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define NAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define NAU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/nau_pkg.sv =====
// types, constants and the exponential table of the activation unit
package nau_pkg;

    localparam int Q_FRAC        = 16;
    localparam int REM_W         = 18;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STAGES    = Q_FRAC / DIV_STEP_BITS;
    localparam int PIPE_DEPTH    = DIV_STAGES + 5;

    localparam logic [31:0] Q_ONE = 32'd65536;
    localparam logic signed [31:0] SAT_HI = 32'sd524288;
    localparam logic signed [31:0] SAT_LO = -32'sd524288;

    localparam logic [1:0] MODE_SIG  = 2'd0;
    localparam logic [1:0] MODE_RELU = 2'd1;
    localparam logic [1:0] MODE_TANH = 2'd2;

    localparam logic [16:0] EXP_TAB [0:32] = '{
        17'd65536, 17'd51034, 17'd39750, 17'd30957, 17'd24108, 17'd18776,
        17'd14624, 17'd11388, 17'd8871,  17'd6909,  17'd5381,  17'd4191,
        17'd3264,  17'd2542,  17'd1980,  17'd1542,  17'd1201,  17'd935,
        17'd728,   17'd567,   17'd442,   17'd344,   17'd268,   17'd209,
        17'd163,   17'd127,   17'd99,    17'd77,    17'd60,    17'd47,
        17'd36,    17'd28,    17'd22
    };

    typedef enum logic [2:0] {
        OP_SIG,
        OP_TANH,
        OP_RELU,
        OP_STEP,
        OP_DSIG,
        OP_DTANH
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        sat_lo;
        logic        sat_hi;
        logic        neg;
        logic [31:0] aux;
    } t_ctl;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [Q_FRAC-1:0] quo;
    } t_div;

endpackage

// ===== design/nau_div_step.sv =====
// restoring divide step, two quotient bits per pipeline stage
module nau_div_step (
    input  nau_pkg::t_div             i_div,
    input  logic [nau_pkg::REM_W-1:0] i_dvsr,
    output nau_pkg::t_div             o_div
);
    import nau_pkg::*;

    t_div           w_cur;
    logic [REM_W:0] w_sh;

    always_comb begin
        w_cur = i_div;
        w_sh  = '0;
        for (int b = 0; b < DIV_STEP_BITS; b++) begin
            w_sh = {w_cur.rem, 1'b0};
            if (w_sh >= {1'b0, i_dvsr}) begin
                w_cur.rem = REM_W'(w_sh - {1'b0, i_dvsr});
                w_cur.quo = {w_cur.quo[Q_FRAC-2:0], 1'b1};
            end else begin
                w_cur.rem = w_sh[REM_W-1:0];
                w_cur.quo = {w_cur.quo[Q_FRAC-2:0], 1'b0};
            end
        end
        o_div = w_cur;
    end

endmodule

// ===== design/neural_activation_unit_core.sv =====
// top level of the pipelined sigmoid, tanh and relu activation unit
//
// usage
// - input channel: i_in_valid / o_in_ready with i_mode, i_derivative, i_value
//   (signed q16.16); a transfer happens when both are high at a rising edge
// - output channel: o_out_valid / i_out_ready with o_result (signed q16.16)
// - mode 0 sigmoid, 1 relu, 2 tanh, 3 sigmoid; i_derivative selects the
//   derivative form computed from an activation output
// - thirteen register stages: input, decode and table, multiply, interpolate,
//   eight divide stages of two quotient bits each, output
// - throughput: one item per cycle while i_out_ready is high, set by the one-bit-per-stage enable chain
// - receiver stall: stages hold, empty stages keep filling so inputs are taken
//   until every stage holds an item; nothing is lost or repeated
// - reset clears all stage valid bits; the pipeline starts empty
module neural_activation_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic               i_derivative,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result
);
    import nau_pkg::*;

    `include "assert_macros.svh"

    localparam int S_MUL = 2;
    localparam int S_EX  = 3;
    localparam int S_OUT = PIPE_DEPTH - 1;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH:0]   w_en;

    // stage 0
    logic [1:0]         r_s0_mode;
    logic               r_s0_der;
    logic signed [31:0] r_s0_value;

    // stage 1
    t_op                w_op;
    logic signed [31:0] w_x;
    logic               w_neg;
    logic [18:0]        w_mag;
    logic [4:0]         w_idx;
    logic [31:0]        w_aux;
    logic signed [17:0] w_diff;
    logic signed [31:0] w_mb;

    t_ctl               r_ctl [1:S_OUT-1];
    logic [16:0]        r_s1_tab;
    logic signed [17:0] r_s1_diff;
    logic [15:0]        r_s1_frac;
    logic signed [31:0] r_s1_ma;
    logic signed [31:0] r_s1_mb;

    // stage 2
    logic [16:0]        r_s2_tab;
    logic signed [34:0] r_s2_ip;
    logic signed [63:0] r_s2_dp;

    // stage 3 and divide stages
    logic [18:0]        w_ex;
    t_ctl               w_ctl3;
    t_div               r_dv [0:DIV_STAGES];
    logic [REM_W-1:0]   r_dd [0:DIV_STAGES];
    t_div               w_dv_nx [0:DIV_STAGES-1];

    // output stage
    logic [31:0]        w_sq;
    logic [31:0]        w_sig;
    logic [31:0]        w_res;
    logic [31:0]        r_out_res;
    t_op                r_out_op;

    // stall chain
    always_comb begin
        w_en[PIPE_DEPTH] = i_out_ready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_mode  <= i_mode;
            r_s0_der   <= i_derivative;
            r_s0_value <= i_value;
        end
    end

    // decode, range split and table lookup
    always_comb begin
        case (r_s0_mode)
            MODE_RELU: w_op = r_s0_der ? OP_STEP  : OP_RELU;
            MODE_TANH: w_op = r_s0_der ? OP_DTANH : OP_TANH;
            default:   w_op = r_s0_der ? OP_DSIG  : OP_SIG;
        endcase
        w_x    = (w_op == OP_TANH) ? {r_s0_value[30:0], 1'b0} : r_s0_value;
        w_neg  = w_x[31];
        w_mag  = w_neg ? (19'd0 - w_x[18:0]) : w_x[18:0];
        w_idx  = w_mag[18:14];
        w_diff = $signed({1'b0, EXP_TAB[{1'b0, w_idx} + 6'd1]})
               - $signed({1'b0, EXP_TAB[{1'b0, w_idx}]});
        w_mb   = (w_op == OP_DTANH) ? r_s0_value : $signed(Q_ONE - r_s0_value);
        case (w_op)
            OP_RELU: w_aux = r_s0_value[31] ? 32'd0 : r_s0_value;
            OP_STEP: w_aux = (r_s0_value > 32'sd0) ? Q_ONE : 32'd0;
            default: w_aux = r_s0_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_ctl[1].op     <= w_op;
            r_ctl[1].sat_lo <= (w_x <= SAT_LO);
            r_ctl[1].sat_hi <= (w_x >= SAT_HI);
            r_ctl[1].neg    <= w_neg;
            r_ctl[1].aux    <= w_aux;
            r_s1_tab        <= EXP_TAB[{1'b0, w_idx}];
            r_s1_diff       <= w_diff;
            r_s1_frac       <= {w_mag[13:0], 2'b00};
            r_s1_ma         <= r_s0_value;
            r_s1_mb         <= w_mb;
        end
    end

    // interpolation and derivative products
    always_ff @(posedge i_clk) begin
        if (w_en[S_MUL]) begin
            r_ctl[S_MUL] <= r_ctl[S_MUL-1];
            r_s2_tab     <= r_s1_tab;
            r_s2_ip      <= 35'(r_s1_diff * $signed({1'b0, r_s1_frac}));
            r_s2_dp      <= r_s1_ma * r_s1_mb;
        end
    end

    // exponential estimate, divisor and derivative finish
    always_comb begin
        w_ex   = {2'b00, r_s2_tab} + r_s2_ip[34:16];
        w_ctl3 = r_ctl[S_MUL];
        case (r_ctl[S_MUL].op)
            OP_DSIG:  w_ctl3.aux = r_s2_dp[47:16];
            OP_DTANH: w_ctl3.aux = Q_ONE - r_s2_dp[47:16];
            default:  w_ctl3.aux = r_ctl[S_MUL].aux;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_EX]) begin
            r_ctl[S_EX]   <= w_ctl3;
            r_dv[0].rem   <= REM_W'(Q_ONE);
            r_dv[0].quo   <= '0;
            r_dd[0]       <= REM_W'(Q_ONE) + w_ex[REM_W-1:0];
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        nau_div_step u_step (
            .i_div  (r_dv[j]),
            .i_dvsr (r_dd[j]),
            .o_div  (w_dv_nx[j])
        );

        always_ff @(posedge i_clk) begin
            if (w_en[S_EX+1+j]) begin
                r_dv[j+1]        <= w_dv_nx[j];
                r_dd[j+1]        <= r_dd[j];
                r_ctl[S_EX+1+j]  <= r_ctl[S_EX+j];
            end
        end
    end

    // mirror, saturation and tanh rescale
    always_comb begin
        w_sq = {{(32-Q_FRAC){1'b0}}, r_dv[DIV_STAGES].quo};
        if (r_ctl[S_OUT-1].sat_lo) begin
            w_sig = 32'd0;
        end else if (r_ctl[S_OUT-1].sat_hi) begin
            w_sig = Q_ONE;
        end else if (r_ctl[S_OUT-1].neg) begin
            w_sig = Q_ONE - w_sq;
        end else begin
            w_sig = w_sq;
        end
        case (r_ctl[S_OUT-1].op)
            OP_SIG:  w_res = w_sig;
            OP_TANH: w_res = {w_sig[30:0], 1'b0} - Q_ONE;
            default: w_res = r_ctl[S_OUT-1].aux;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_out_res <= w_res;
            r_out_op  <= r_ctl[S_OUT-1].op;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[S_OUT];
    assign o_result    = r_out_res;

    `NAU_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input blocked with empty output stage")
    `NAU_ASSERT(a_transfer_enters, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_vld[0], "accepted transfer not held in first stage")
    `NAU_ASSERT(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_out_valid, "output valid right after reset")
    `NAU_ASSERT(a_sig_range, i_clk, i_rst_n, o_out_valid && (r_out_op == OP_SIG) |-> !o_result[31] && (o_result <= 32'sd65536), "sigmoid result out of range")

endmodule
